[rtl/dsadc_pkg.sv]
// ----------------------------------------------------------------------------
// dsadc_pkg
// Shared constants for the dual-slope ADC sequencer: event kinds, switch
// network codes, result widths and the register reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package dsadc_pkg;

    // Result count field width
    localparam int CountOutBits = 16;

    // Configuration register width and reset value
    localparam int PhaseTickBits = 8;
    localparam logic [PhaseTickBits-1:0] PHASE_TICKS_RESET = 8'd64;

    // Event kinds carried in op
    localparam logic OP_SLOW = 1'b0;
    localparam logic OP_FAST = 1'b1;

    // Switch network codes, {switch_a, switch_b}
    localparam logic [1:0] SW_ZEROING   = 2'b01;
    localparam logic [1:0] SW_INTEGRATE = 2'b10;
    localparam logic [1:0] SW_DEINT     = 2'b11;
    localparam logic [1:0] SW_OFF       = 2'b00;

endpackage

`default_nettype wire

[rtl/dual_slope_adc_sequencer.sv]
// ----------------------------------------------------------------------------
// dual_slope_adc_sequencer
// Free-running dual-slope integrator sequencer: zeroing, integration,
// de-integration with a saturating fast-tick count, and a done report.
// ----------------------------------------------------------------------------
// Results: each result is loaded into the output register when its event is accepted.
// Throughput: one event per cycle; the phase update is one compare and add
// on the state registers, and the single output register stalls the input
// only while its result is held by the receiver.
// Reset: rst_n clears to the zeroing phase with phase_ticks at 64 and an
// empty output register; no clearing pass is needed.
`default_nettype none

module dual_slope_adc_sequencer
    import dsadc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration write channel
    input  wire logic                     cfg_valid,
    output      logic                     cfg_ready,
    input  wire logic [PhaseTickBits-1:0] cfg_phase_ticks,
    // event channel
    input  wire logic                     in_valid,
    output      logic                     in_stall,
    input  wire logic                     op,
    input  wire logic                     comparator,
    // result channel
    output      logic                     out_valid,
    input  wire logic                     out_stall,
    output      logic                     switch_a,
    output      logic                     switch_b,
    output      logic                     done_res,
    output      logic [CountOutBits-1:0]  count,
    output      logic                     sign
);

    localparam int ExtBits = (COUNT_BITS > CountOutBits) ? COUNT_BITS : CountOutBits;
    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_ZERO  = 2'd0,
        PH_INTEG = 2'd1,
        PH_DEINT = 2'd2,
        PH_OFF   = 2'd3
    } phase_t;

    // state
    phase_t                   phase_reg, phase_next, phase_evt;
    logic [PhaseTickBits-1:0] tick_reg, tick_next, tick_inc;
    logic [COUNT_BITS-1:0]    deint_reg, deint_next;
    logic                     sign_reg, sign_next;
    logic [PhaseTickBits-1:0] phase_ticks_reg, phase_ticks_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               sw_reg, sw_next;
    logic                     done_reg, done_next;
    logic [CountOutBits-1:0]  count_reg, count_next;
    logic                     res_sign_reg, res_sign_next;

    logic                     in_accept;
    logic [ExtBits-1:0]       deint_ext;
    logic [CountOutBits-1:0]  count_sat;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // saturate the reported count to the result width
    assign deint_ext = ExtBits'(deint_reg);
    assign count_sat = (deint_ext > ExtBits'({CountOutBits{1'b1}}))
                       ? {CountOutBits{1'b1}} : deint_ext[CountOutBits-1:0];

    assign tick_inc = tick_reg + 8'd1;

    // phase update for one event
    always_comb
    begin
        phase_evt     = phase_reg;
        tick_next     = tick_reg;
        deint_next    = deint_reg;
        sign_next     = sign_reg;
        done_next     = 1'b0;
        count_next    = '0;
        res_sign_next = 1'b0;

        case (phase_reg)
            PH_ZERO:
            begin
                if (op == OP_SLOW)
                begin
                    if (tick_inc >= phase_ticks_reg)
                    begin
                        tick_next = '0;
                        phase_evt = PH_INTEG;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            PH_INTEG:
            begin
                if (op == OP_SLOW)
                begin
                    if (tick_inc >= phase_ticks_reg)
                    begin
                        tick_next  = '0;
                        sign_next  = comparator;
                        deint_next = '0;
                        phase_evt  = PH_DEINT;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            PH_DEINT:
            begin
                if (comparator != sign_reg)
                begin
                    done_next     = 1'b1;
                    count_next    = count_sat;
                    res_sign_next = sign_reg;
                    phase_evt     = PH_OFF;
                end
                else if (op == OP_FAST && deint_reg != CountMax)
                begin
                    deint_next = deint_reg + COUNT_BITS'(1);
                end
            end
            default:
            begin
                tick_next = '0;
                phase_evt = PH_ZERO;
            end
        endcase

        // drive the switches from the phase this event ends in
        case (phase_evt)
            PH_ZERO:  sw_next = SW_ZEROING;
            PH_INTEG: sw_next = SW_INTEGRATE;
            PH_DEINT: sw_next = SW_DEINT;
            default:  sw_next = SW_OFF;
        endcase

        // off lasts only for the ending event; restart with zeroing
        phase_next = phase_evt;
        if (phase_evt == PH_OFF)
        begin
            tick_next  = '0;
            phase_next = PH_ZERO;
        end
    end

    // register and output valid
    always_comb
    begin
        phase_ticks_next = phase_ticks_reg;
        if (cfg_valid && cfg_ready)
        begin
            phase_ticks_next = cfg_phase_ticks;
        end

        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // hold state, configuration and the result register; load the result
    // payload with each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_ZERO;
            tick_reg        <= '0;
            deint_reg       <= '0;
            sign_reg        <= 1'b0;
            phase_ticks_reg <= PHASE_TICKS_RESET;
            out_valid_reg   <= 1'b0;
            sw_reg          <= SW_OFF;
            done_reg        <= 1'b0;
            count_reg       <= '0;
            res_sign_reg    <= 1'b0;
        end
        else
        begin
            phase_ticks_reg <= phase_ticks_next;
            out_valid_reg   <= out_valid_next;
            if (in_accept)
            begin
                phase_reg    <= phase_next;
                tick_reg     <= tick_next;
                deint_reg    <= deint_next;
                sign_reg     <= sign_next;
                sw_reg       <= sw_next;
                done_reg     <= done_next;
                count_reg    <= count_next;
                res_sign_reg <= res_sign_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign switch_a  = sw_reg[1];
    assign switch_b  = sw_reg[0];
    assign done_res  = done_reg;
    assign count     = count_reg;
    assign sign      = res_sign_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_switches_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (sw_reg == SW_OFF))
        else $error("done result without switches off");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_reg) |-> (count_reg == '0 && !res_sign_reg))
        else $error("count or sign set on a result without done");

    a_off_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_OFF)
        else $error("off phase held past the ending event");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_deint_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DEINT && $past(phase_reg) != PH_DEINT) |-> (deint_reg == '0))
        else $error("de-integration count not cleared on entry");

endmodule

`default_nettype wire

[tb/sv/dual_slope_adc_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// dual_slope_adc_sequencer_tb
// Self-checking bench for the dual-slope ADC sequencer. A directed table
// covers reset, the phase edge cases and the register extremes. Random
// conversions with noise follow. Every result is checked against its table row
// or an in-bench sequencer model, under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dual_slope_adc_sequencer_tb;
    import dsadc_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_EVENTS = 1600;
    localparam logic [PhaseTickBits-1:0] TICK_SETTINGS [8] =
        '{8'd4, 8'd255, 8'd1, 8'd0, 8'd2, 8'd64, 8'd9, 8'd3};

    typedef enum logic [1:0] {ZEROING, INTEGRATING, DEINTEGRATING, SWITCHED_OFF} seq_phase_t;
    typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic                    sw_a;
        logic                    sw_b;
        logic                    done;
        logic [CountOutBits-1:0] count;
        logic                    sign;
    } conv_result_t;

    typedef struct packed {
        row_kind_t                kind;
        logic                     op;
        logic                     cmp;
        logic [PhaseTickBits-1:0] value;
        bit                       typed;
        conv_result_t             res;
    } stim_row_t;

    logic                     clk             = 1'b0;
    logic                     rst_n           = 1'b0;
    logic                     cfg_valid       = 1'b0;
    logic                     cfg_ready;
    logic [PhaseTickBits-1:0] cfg_phase_ticks = '0;
    logic                     in_valid        = 1'b0;
    logic                     in_stall;
    logic                     op              = OP_SLOW;
    logic                     comparator      = 1'b0;
    logic                     out_valid;
    logic                     out_stall       = 1'b0;
    logic                     switch_a;
    logic                     switch_b;
    logic                     done_res;
    logic [CountOutBits-1:0]  count;
    logic                     sign;

    // Sequencer model state
    seq_phase_t               mdl_phase       = ZEROING;
    logic [7:0]               mdl_ticks       = '0;
    logic [15:0]              mdl_deint       = '0;
    logic                     mdl_sign        = 1'b0;
    logic [PhaseTickBits-1:0] mdl_phase_ticks = PHASE_TICKS_RESET;

    conv_result_t pending_results [$];
    bit           quiet        = 1'b0;
    int           fail_count   = 0;
    int           n_events     = 0;
    int           n_conversion = 0;
    int           n_drains     = 0;
    int           max_count    = 0;
    int           cycles       = 0;

    dual_slope_adc_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_phase_ticks (cfg_phase_ticks),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .comparator      (comparator),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .switch_a        (switch_a),
        .switch_b        (switch_b),
        .done_res        (done_res),
        .count           (count),
        .sign            (sign)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("dual_slope_adc_sequencer_tb failed");
            $finish;
        end
    end

    // Advance the model by one event and return the result it produces
    task automatic predict_sequencer_step(input logic ev_op, input logic ev_cmp,
                                          output conv_result_t r);
        r = '0;
        case (mdl_phase)
            ZEROING:
                if (ev_op == OP_SLOW)
                begin
                    mdl_ticks = mdl_ticks + 8'd1;
                    if (mdl_ticks >= mdl_phase_ticks)
                    begin
                        mdl_ticks = '0;
                        mdl_phase = INTEGRATING;
                    end
                end
            INTEGRATING:
                if (ev_op == OP_SLOW)
                begin
                    mdl_ticks = mdl_ticks + 8'd1;
                    if (mdl_ticks >= mdl_phase_ticks)
                    begin
                        mdl_ticks = '0;
                        mdl_sign  = ev_cmp;
                        mdl_deint = '0;
                        mdl_phase = DEINTEGRATING;
                    end
                end
            DEINTEGRATING:
                // A comparator change ends the conversion on any event kind
                if (ev_cmp != mdl_sign)
                begin
                    r.done    = 1'b1;
                    r.count   = mdl_deint;
                    r.sign    = mdl_sign;
                    mdl_phase = SWITCHED_OFF;
                    n_conversion++;
                    if (int'(mdl_deint) > max_count)
                        max_count = int'(mdl_deint);
                end
                else if (ev_op == OP_FAST && mdl_deint != '1)
                    mdl_deint = mdl_deint + 16'd1;
            default:
            begin
                mdl_ticks = '0;
                mdl_phase = ZEROING;
            end
        endcase

        case (mdl_phase)
            ZEROING:       {r.sw_a, r.sw_b} = SW_ZEROING;
            INTEGRATING:   {r.sw_a, r.sw_b} = SW_INTEGRATE;
            DEINTEGRATING: {r.sw_a, r.sw_b} = SW_DEINT;
            default:       {r.sw_a, r.sw_b} = SW_OFF;
        endcase

        // Off lasts only for the ending event
        if (mdl_phase == SWITCHED_OFF)
        begin
            mdl_ticks = '0;
            mdl_phase = ZEROING;
        end
    endtask

    // Offer one event, wait for its transaction and queue the expected result
    task automatic send_event(input logic ev_op, input logic ev_cmp,
                              input bit has_typed, input conv_result_t typed_res);
        int           gap;
        conv_result_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= ev_op;
        comparator <= ev_cmp;
        do @(negedge clk); while (in_stall !== 1'b0);
        @(posedge clk);
        predict_sequencer_step(ev_op, ev_cmp, predicted);
        pending_results.push_back(has_typed ? typed_res : predicted);
        n_events++;
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        // Let the output register settle before touching the register
        repeat (2) @(posedge clk);
        n_drains++;
    endtask

    task automatic write_phase_ticks(input logic [PhaseTickBits-1:0] value);
        drain_results();
        cfg_valid       <= 1'b1;
        cfg_phase_ticks <= value;
        do @(negedge clk); while (cfg_ready !== 1'b1);
        @(posedge clk);
        cfg_valid       <= 1'b0;
        mdl_phase_ticks  = value;
    endtask

    function automatic stim_row_t ev(input logic o, input logic c);
        return '{ROW_EVENT, o, c, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t ev_exp(input logic o, input logic c, input logic [1:0] sw,
                                         input logic d, input logic [CountOutBits-1:0] n,
                                         input logic s);
        return '{ROW_EVENT, o, c, '0, 1'b1, '{sw[1], sw[0], d, n, s}};
    endfunction

    function automatic stim_row_t wr(input logic [PhaseTickBits-1:0] v);
        return '{ROW_WRITE, OP_SLOW, 1'b0, v, 1'b0, '0};
    endfunction

    // Take results under random stall and compare them with the oldest expectation
    initial
    begin : result_check
        int           hold;
        bit           bad;
        conv_result_t got;
        conv_result_t want;
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(negedge clk); while (out_valid !== 1'b1);
            got = '{switch_a, switch_b, done_res, count, sign};
            @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                bad  = 1'b0;
                if (got.sw_a !== want.sw_a)
                begin
                    $error("switch_a: expected %0d, actual %0d", want.sw_a, got.sw_a);
                    bad = 1'b1;
                end
                if (got.sw_b !== want.sw_b)
                begin
                    $error("switch_b: expected %0d, actual %0d", want.sw_b, got.sw_b);
                    bad = 1'b1;
                end
                if (got.done !== want.done)
                begin
                    $error("done_res: expected %0d, actual %0d", want.done, got.done);
                    bad = 1'b1;
                end
                if (got.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, got.count);
                    bad = 1'b1;
                end
                if (got.sign !== want.sign)
                begin
                    $error("sign: expected %0d, actual %0d", want.sign, got.sign);
                    bad = 1'b1;
                end
                if (bad)
                    fail_count++;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t  table_rows [$];
        int         effective;
        int         random_conv;
        int         since_write;
        int         deint_left;
        int         next_setting;
        int         conv_before;
        seq_phase_t was;
        logic       r_op;
        logic       r_cmp;

        effective    = 0;
        random_conv  = 0;
        since_write  = 0;
        deint_left   = 0;
        next_setting = 0;

        table_rows = '{
            // after reset: zeroing, fast tick ignored
            ev_exp(OP_SLOW, 1'b0, SW_ZEROING, 1'b0, 16'd0, 1'b0),
            ev_exp(OP_FAST, 1'b1, SW_ZEROING, 1'b0, 16'd0, 1'b0),
            wr(8'd1),
            // integrate, fast tick ignored, capture positive sign
            ev(OP_SLOW, 1'b0),
            ev(OP_FAST, 1'b0),
            ev(OP_SLOW, 1'b1),
            // two counted fast ticks, one uncounted slow tick
            ev(OP_FAST, 1'b1),
            ev(OP_FAST, 1'b1),
            ev(OP_SLOW, 1'b1),
            // changing fast tick ends the conversion and is not counted
            ev_exp(OP_FAST, 1'b0, SW_OFF, 1'b1, 16'd2, 1'b1),
            ev(OP_FAST, 1'b1),
            // zero phase length behaves as one
            wr(8'd0),
            ev(OP_SLOW, 1'b0),
            ev(OP_SLOW, 1'b0),
            // slow tick with a comparator change ends de-integration
            ev_exp(OP_SLOW, 1'b1, SW_OFF, 1'b1, 16'd0, 1'b0),
            ev(OP_SLOW, 1'b1),
            ev(OP_SLOW, 1'b1),
            ev_exp(OP_FAST, 1'b0, SW_OFF, 1'b1, 16'd0, 1'b1),
            wr(8'd255),
            ev(OP_SLOW, 1'b1)
        };

        // Hold reset, then release at a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (table_rows[i])
        begin
            if (table_rows[i].kind == ROW_WRITE)
                write_phase_ticks(table_rows[i].value);
            else
                send_event(table_rows[i].op, table_rows[i].cmp,
                           table_rows[i].typed, table_rows[i].res);
        end

        // Random conversions with noise, register changes and drains
        while (effective < RANDOM_EVENTS || random_conv < 48)
        begin
            if (since_write >= ((mdl_phase_ticks >= 8'd64) ? 1 : 8))
            begin
                write_phase_ticks(TICK_SETTINGS[next_setting]);
                next_setting = (next_setting + 1) % 8;
                since_write  = 0;
            end
            else if ($urandom_range(0, 199) == 0)
                write_phase_ticks(8'($urandom_range(0, 10)));
            else if ($urandom_range(0, 99) == 0)
                drain_results();

            if ($urandom_range(0, 99) == 0)
                quiet = !quiet;

            if ($urandom_range(0, 9) == 0)
            begin
                r_op  = 1'($urandom);
                r_cmp = 1'($urandom);
            end
            else if (mdl_phase == DEINTEGRATING && deint_left > 0)
            begin
                r_op  = ($urandom_range(0, 6) != 0) ? OP_FAST : OP_SLOW;
                r_cmp = mdl_sign;
                deint_left--;
            end
            else if (mdl_phase == DEINTEGRATING)
            begin
                r_op  = 1'($urandom);
                r_cmp = ~mdl_sign;
            end
            else
            begin
                r_op  = ($urandom_range(0, 4) != 0) ? OP_SLOW : OP_FAST;
                r_cmp = 1'($urandom);
            end

            was         = mdl_phase;
            conv_before = n_conversion;
            send_event(r_op, r_cmp, 1'b0, '0);

            // Fast ticks outside de-integration do nothing
            if (!(r_op == OP_FAST && (was == ZEROING || was == INTEGRATING)))
                effective++;
            if (mdl_phase == DEINTEGRATING && was != DEINTEGRATING)
                deint_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                         : $urandom_range(0, 12);
            if (n_conversion != conv_before)
            begin
                since_write++;
                random_conv++;
            end
        end

        // Wait for the tail, then allow time for stray results
        quiet = 1'b0;
        drain_results();
        repeat (4) @(posedge clk);

        $display("%0d events, %0d conversions checked, longest count %0d",
                 n_events, n_conversion, max_count);
        $display("phase_ticks from 0 to 255 incl. mid-phase writes, %0d full drains",
                 n_drains);
        if (fail_count == 0)
            $display("dual_slope_adc_sequencer_tb passed");
        else
            $display("dual_slope_adc_sequencer_tb failed");
        $finish;
    end

endmodule
